// ----- hdl/p2q_pkg.sv -----
// p2q_pkg: shared constants, register codes and request/response types
// for the pixel to momentum transfer unit. No dependencies.

package p2q_pkg;

    localparam int COORD_W   = 24;
    localparam int COEF_W    = 18;
    localparam int OUT_W     = 28;
    localparam int WAVE_W    = 24;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_WAVE   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] q_in_plane;
        logic signed [OUT_W-1:0] q_out_of_plane;
        logic                    zero_position;
    } rsp_t;

endpackage

// ----- hdl/p2q_sqrt.sv -----
// p2q_sqrt: pipelined integer square root, one result bit per stage,
// floor root plus remainder, with a sideband carried alongside. No dependencies.

module p2q_sqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [IN_W/2-1:0]     root,
    output logic [IN_W/2+1:0]     rem,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RW = IN_W / 2;
    localparam int MW = RW + 2;

    logic              vld_reg  [RW];
    logic [IN_W-1:0]   rad_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [MW-1:0]     rem_reg  [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    logic              vld_cur  [RW];
    logic [IN_W-1:0]   rad_cur  [RW];
    logic [RW-1:0]     root_cur [RW];
    logic [MW-1:0]     rem_cur  [RW];
    logic [SIDE_W-1:0] side_cur [RW];

    logic [IN_W-1:0]   rad_next  [RW];
    logic [RW-1:0]     root_next [RW];
    logic [MW-1:0]     rem_next  [RW];

    always_comb
    begin
        vld_cur[0]  = in_valid;
        rad_cur[0]  = radicand;
        root_cur[0] = '0;
        rem_cur[0]  = '0;
        side_cur[0] = in_side;
        for (int s = 1; s < RW; s++)
        begin
            vld_cur[s]  = vld_reg[s-1];
            rad_cur[s]  = rad_reg[s-1];
            root_cur[s] = root_reg[s-1];
            rem_cur[s]  = rem_reg[s-1];
            side_cur[s] = side_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < RW; s++)
        begin
            logic [MW-1:0] t;
            logic [MW-1:0] trial;
            logic          take;
            t     = {rem_cur[s][RW-1:0], rad_cur[s][IN_W-1 -: 2]};
            trial = {root_cur[s], 2'b01};
            take  = t >= trial;
            rad_next[s]  = rad_cur[s] << 2;
            root_next[s] = {root_cur[s][RW-2:0], take};
            rem_next[s]  = take ? t - trial : t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < RW; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < RW; s++)
            begin
                vld_reg[s] <= vld_cur[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RW; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            root_reg[s] <= root_next[s];
            rem_reg[s]  <= rem_next[s];
            side_reg[s] <= side_cur[s];
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign rem       = rem_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ----- hdl/p2q_div.sv -----
// p2q_div: pipelined restoring divider, three lanes sharing one divisor,
// one quotient bit per stage, sideband carried alongside. No dependencies.

module p2q_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 33,
    parameter int QW     = 28,
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [2:0][NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]           den,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [2:0][QW-1:0]         quo,
    output logic [SIDE_W-1:0]          out_side
);

    logic                   vld_reg  [QW];
    logic [DEN_W-1:0]       den_reg  [QW];
    logic [2:0][DEN_W-1:0]  rem_reg  [QW];
    logic [2:0][QW-1:0]     lo_reg   [QW];
    logic [2:0][QW-1:0]     quo_reg  [QW];
    logic [SIDE_W-1:0]      side_reg [QW];

    logic                   vld_cur  [QW];
    logic [DEN_W-1:0]       den_cur  [QW];
    logic [2:0][DEN_W-1:0]  rem_cur  [QW];
    logic [2:0][QW-1:0]     lo_cur   [QW];
    logic [2:0][QW-1:0]     quo_cur  [QW];
    logic [SIDE_W-1:0]      side_cur [QW];

    logic [2:0][DEN_W-1:0]  rem_next [QW];
    logic [2:0][QW-1:0]     lo_next  [QW];
    logic [2:0][QW-1:0]     quo_next [QW];

    always_comb
    begin
        vld_cur[0]  = in_valid;
        den_cur[0]  = den;
        side_cur[0] = in_side;
        for (int l = 0; l < 3; l++)
        begin
            rem_cur[0][l] = num[l][QW +: DEN_W];
            lo_cur[0][l]  = num[l][QW-1:0];
            quo_cur[0][l] = '0;
        end
        for (int s = 1; s < QW; s++)
        begin
            vld_cur[s]  = vld_reg[s-1];
            den_cur[s]  = den_reg[s-1];
            rem_cur[s]  = rem_reg[s-1];
            lo_cur[s]   = lo_reg[s-1];
            quo_cur[s]  = quo_reg[s-1];
            side_cur[s] = side_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [DEN_W:0] t;
                logic [DEN_W:0] diff;
                logic           take;
                t    = {rem_cur[s][l], lo_cur[s][l][QW-1]};
                diff = t - {1'b0, den_cur[s]};
                take = t >= {1'b0, den_cur[s]};
                rem_next[s][l] = take ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                lo_next[s][l]  = lo_cur[s][l] << 1;
                quo_next[s][l] = {quo_cur[s][l][QW-2:0], take};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < QW; s++)
            begin
                vld_reg[s] <= vld_cur[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QW; s++)
        begin
            den_reg[s]  <= den_cur[s];
            rem_reg[s]  <= rem_next[s];
            lo_reg[s]   <= lo_next[s];
            quo_reg[s]  <= quo_next[s];
            side_reg[s] <= side_cur[s];
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- hdl/pixel_to_momentum_transfer_unit.sv -----
// pixel_to_momentum_transfer_unit: top level, pixel position to momentum transfer.
// Depends on p2q_pkg, p2q_sqrt, p2q_div.
//
// channel   | handshake              | payload
// ----------+------------------------+----------------------------------
// request   | start, busy            | req (pos_x, pos_y, pos_z)
// response  | done (one-cycle strobe)| rsp (q_in_plane, q_out_of_plane,
//           |                        |      zero_position)
// config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One request is taken every cycle; busy stays low. Each request passes in order
// through stages S1-S5, the length square root, S6-S8, the divider, S9-S13, the
// magnitude square root and the output register S14; the square roots and the
// divider each work one bit per stage. Reset clears the valid pipeline and loads
// the identity matrix, zero offset and unit wave number. The receiver cannot
// stall, so the pipeline never holds.

module pixel_to_momentum_transfer_unit
    import p2q_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NORM_W = 32;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int LEN_W  = NORM_W;
    localparam int P_W    = NORM_W + 1;
    localparam int PROD_W = COEF_W + P_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int DEN_W  = LEN_W + 1;
    localparam int QUO_W  = COEF_W + 10;
    localparam int NUM_W  = QUO_W + DEN_W;
    localparam int A_W    = QUO_W + 1;
    localparam int MJ_W   = QUO_W + 2;
    localparam int V_W    = MJ_W + WAVE_W + 1;
    localparam int VQ_SH  = 40 - FRAC_BITS;
    localparam int QM_W   = V_W + 1 - VQ_SH;
    localparam int RS_W   = 2 * QM_W + 2;
    localparam int RT_W   = QM_W + 1;
    localparam int SAT_A  = (RT_W + 2 > QM_W + 2) ? RT_W + 2 : QM_W + 2;
    localparam int SAT_W  = (SAT_A > OUT_W + 1) ? SAT_A : OUT_W + 1;
    localparam int S1_SIDE = 3 * NORM_W + 4;
    localparam int S2_SIDE = QM_W + 3;
    localparam int LAT    = 5 + LEN_W + 3 + QUO_W + 5 + RT_W + 1;

    localparam logic signed [SAT_W-1:0] OMAX = (SAT_W'(1) <<< (OUT_W - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] OMIN = -OMAX - SAT_W'(1);
    localparam logic [V_W:0] RND = (V_W+1)'(1) << (VQ_SH - 1);

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        r = v;
        if (v > OMAX)
        begin
            r = OMAX;
        end
        else if (v < OMIN)
        begin
            r = OMIN;
        end
        return r[OUT_W-1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0]  row_reg [3];
    logic [CFG_W-1:0]  off_reg;
    logic [WAVE_W-1:0] wave_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= CFG_W'(1) << FRAC_BITS;
            row_reg[1] <= CFG_W'(1) << (FRAC_BITS + COEF_W);
            row_reg[2] <= CFG_W'(1) << (FRAC_BITS + 2 * COEF_W);
            off_reg    <= '0;
            wave_reg   <= WAVE_W'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ROW0:   row_reg[0] <= cfg_data;
                CFG_ROW1:   row_reg[1] <= cfg_data;
                CFG_ROW2:   row_reg[2] <= cfg_data;
                CFG_OFFSET: off_reg    <= cfg_data;
                CFG_WAVE:   wave_reg   <= cfg_data[WAVE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // S1: magnitudes
    logic signed [COORD_W-1:0] pos [3];
    assign pos[0] = req.pos_x;
    assign pos[1] = req.pos_y;
    assign pos[2] = req.pos_z;

    logic               s1_vld_reg;
    logic [COORD_W-1:0] s1_mag_reg [3];
    logic [2:0]         s1_neg_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_mag_reg[i] <= pos[i][COORD_W-1] ? COORD_W'(-pos[i]) : COORD_W'(pos[i]);
            s1_neg_reg[i] <= pos[i][COORD_W-1];
        end
    end

    // S2: zero check, coarse normalize
    logic [NORM_W-1:0] s2_mag_next [3];
    logic [NORM_W-1:0] s2_or_next;
    logic              s2_vld_reg;
    logic [NORM_W-1:0] s2_mag_reg [3];
    logic [NORM_W-1:0] s2_or_reg;
    logic [2:0]        s2_neg_reg;
    logic              s2_zero_reg;

    always_comb
    begin
        logic [NORM_W-1:0] o;
        logic [NORM_W-1:0] m [3];
        for (int i = 0; i < 3; i++)
        begin
            m[i] = NORM_W'(s1_mag_reg[i]);
        end
        o = m[0] | m[1] | m[2];
        if (o[NORM_W-1 -: 17] == '0)
        begin
            o = o << 16;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 16;
        end
        if (o[NORM_W-1 -: 9] == '0)
        begin
            o = o << 8;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 8;
        end
        s2_or_next = o;
        s2_mag_next = m;
    end

    always_ff @(posedge clk)
    begin
        s2_mag_reg  <= s2_mag_next;
        s2_or_reg   <= s2_or_next;
        s2_neg_reg  <= s1_neg_reg;
        s2_zero_reg <= (s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2]) == '0;
    end

    // S3: fine normalize
    logic [NORM_W-1:0] s3_mag_next [3];
    logic              s3_vld_reg;
    logic [NORM_W-1:0] s3_mag_reg [3];
    logic [2:0]        s3_neg_reg;
    logic              s3_zero_reg;

    always_comb
    begin
        logic [NORM_W-1:0] o;
        logic [NORM_W-1:0] m [3];
        o = s2_or_reg;
        m = s2_mag_reg;
        if (o[NORM_W-1 -: 5] == '0)
        begin
            o = o << 4;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 4;
        end
        if (o[NORM_W-1 -: 3] == '0)
        begin
            o = o << 2;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 2;
        end
        if (o[NORM_W-1 -: 2] == '0)
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s3_mag_next = m;
    end

    always_ff @(posedge clk)
    begin
        s3_mag_reg  <= s3_mag_next;
        s3_neg_reg  <= s2_neg_reg;
        s3_zero_reg <= s2_zero_reg;
    end

    // S4: squares, S5: sum
    logic              s4_vld_reg;
    logic [SQ_W-1:0]   s4_sq_reg [3];
    logic [NORM_W-1:0] s4_mag_reg [3];
    logic [2:0]        s4_neg_reg;
    logic              s4_zero_reg;
    logic              s5_vld_reg;
    logic [SQ_W-1:0]   s5_sum_reg;
    logic [NORM_W-1:0] s5_mag_reg [3];
    logic [2:0]        s5_neg_reg;
    logic              s5_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_sq_reg[i] <= SQ_W'(s3_mag_reg[i]) * SQ_W'(s3_mag_reg[i]);
        end
        s4_mag_reg  <= s3_mag_reg;
        s4_neg_reg  <= s3_neg_reg;
        s4_zero_reg <= s3_zero_reg;
        s5_sum_reg  <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];
        s5_mag_reg  <= s4_mag_reg;
        s5_neg_reg  <= s4_neg_reg;
        s5_zero_reg <= s4_zero_reg;
    end

    // length square root
    logic               len_vld;
    logic [LEN_W-1:0]   len_root;
    logic [S1_SIDE-1:0] len_side;

    p2q_sqrt #(
        .IN_W   (SQ_W),
        .SIDE_W (S1_SIDE)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_vld_reg),
        .radicand  (s5_sum_reg),
        .in_side   ({s5_zero_reg, s5_neg_reg, s5_mag_reg[2], s5_mag_reg[1], s5_mag_reg[0]}),
        .out_valid (len_vld),
        .root      (len_root),
        .rem       (),
        .out_side  (len_side)
    );

    // S6: products
    logic signed [P_W-1:0] pv [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [P_W-1:0] pm;
            pm    = $signed({1'b0, len_side[i*NORM_W +: NORM_W]});
            pv[i] = len_side[3*NORM_W + i] ? -pm : pm;
        end
    end

    logic                     s6_vld_reg;
    logic signed [PROD_W-1:0] s6_prod_reg [3][3];
    logic [LEN_W-1:0]         s6_len_reg;
    logic                     s6_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_prod_reg[j][i] <= PROD_W'($signed(row_reg[j][i*COEF_W +: COEF_W]))
                                   * PROD_W'(pv[i]);
            end
        end
        s6_len_reg  <= len_root;
        s6_zero_reg <= len_side[S1_SIDE-1];
    end

    // S7: dot products
    logic                    s7_vld_reg;
    logic signed [DOT_W-1:0] s7_dot_reg [3];
    logic [LEN_W-1:0]        s7_len_reg;
    logic                    s7_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            s7_dot_reg[j] <= DOT_W'(s6_prod_reg[j][0]) + DOT_W'(s6_prod_reg[j][1])
                           + DOT_W'(s6_prod_reg[j][2]);
        end
        s7_len_reg  <= s6_len_reg;
        s7_zero_reg <= s6_zero_reg;
    end

    // S8: rounding numerators
    logic                  s8_vld_reg;
    logic [2:0][NUM_W-1:0] s8_num_reg;
    logic [DEN_W-1:0]      s8_den_reg;
    logic [2:0]            s8_neg_reg;
    logic                  s8_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic [DOT_W-1:0] dm;
            dm = s7_dot_reg[j][DOT_W-1] ? DOT_W'(-s7_dot_reg[j]) : DOT_W'(s7_dot_reg[j]);
            s8_num_reg[j] <= NUM_W'({dm, 9'b0}) + NUM_W'(s7_len_reg);
            s8_neg_reg[j] <= s7_dot_reg[j][DOT_W-1];
        end
        s8_den_reg  <= {s7_len_reg, 1'b0};
        s8_zero_reg <= s7_zero_reg;
    end

    logic                  div_vld;
    logic [2:0][QUO_W-1:0] div_quo;
    logic [3:0]            div_side;

    p2q_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QW     (QUO_W),
        .SIDE_W (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s8_vld_reg),
        .num       (s8_num_reg),
        .den       (s8_den_reg),
        .in_side   ({s8_zero_reg, s8_neg_reg}),
        .out_valid (div_vld),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    // S9: sign, offset
    logic                   s9_vld_reg;
    logic signed [MJ_W-1:0] s9_mj_reg [3];
    logic                   s9_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic signed [A_W-1:0] am;
            logic signed [A_W-1:0] a;
            am = $signed({1'b0, div_quo[j]});
            a  = div_side[j] ? -am : am;
            s9_mj_reg[j] <= MJ_W'(a)
                          - (MJ_W'($signed(off_reg[j*COEF_W +: COEF_W])) <<< 8);
        end
        s9_zero_reg <= div_side[3];
    end

    // S10: wave number scale
    logic                  s10_vld_reg;
    logic signed [V_W-1:0] s10_v_reg [3];
    logic                  s10_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            s10_v_reg[j] <= V_W'(s9_mj_reg[j]) * V_W'($signed({1'b0, wave_reg}));
        end
        s10_zero_reg <= s9_zero_reg;
    end

    // S11: round to 16 fraction bits
    logic              s11_vld_reg;
    logic [QM_W-1:0]   s11_qm_reg [3];
    logic [2:0]        s11_neg_reg;
    logic              s11_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic [V_W-1:0] vm;
            logic [V_W:0]   sum;
            vm  = s10_v_reg[j][V_W-1] ? V_W'(-s10_v_reg[j]) : V_W'(s10_v_reg[j]);
            sum = {1'b0, vm} + RND;
            s11_qm_reg[j]  <= sum[V_W:VQ_SH];
            s11_neg_reg[j] <= s10_v_reg[j][V_W-1] && (sum[V_W:VQ_SH] != '0);
        end
        s11_zero_reg <= s10_zero_reg;
    end

    // S12: squares, S13: sum
    logic                    s12_vld_reg;
    logic [2*QM_W-1:0]       s12_sq_reg [2];
    logic signed [QM_W:0]    s12_q2_reg;
    logic                    s12_neg0_reg;
    logic                    s12_zero_reg;
    logic                    s13_vld_reg;
    logic [RS_W-1:0]         s13_rs_reg;
    logic signed [QM_W:0]    s13_q2_reg;
    logic                    s13_neg0_reg;
    logic                    s13_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 2; j++)
        begin
            s12_sq_reg[j] <= (2*QM_W)'(s11_qm_reg[j]) * (2*QM_W)'(s11_qm_reg[j]);
        end
        s12_q2_reg   <= s11_neg_reg[2] ? -$signed({1'b0, s11_qm_reg[2]})
                                       : $signed({1'b0, s11_qm_reg[2]});
        s12_neg0_reg <= s11_neg_reg[0];
        s12_zero_reg <= s11_zero_reg;
        s13_rs_reg   <= RS_W'(s12_sq_reg[0]) + RS_W'(s12_sq_reg[1]);
        s13_q2_reg   <= s12_q2_reg;
        s13_neg0_reg <= s12_neg0_reg;
        s13_zero_reg <= s12_zero_reg;
    end

    logic               mag_vld;
    logic [RT_W-1:0]    mag_root;
    logic [RT_W+1:0]    mag_rem;
    logic [S2_SIDE-1:0] mag_side;

    p2q_sqrt #(
        .IN_W   (RS_W),
        .SIDE_W (S2_SIDE)
    ) u_mag_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s13_vld_reg),
        .radicand  (s13_rs_reg),
        .in_side   ({s13_zero_reg, s13_neg0_reg, s13_q2_reg}),
        .out_valid (mag_vld),
        .root      (mag_root),
        .rem       (mag_rem),
        .out_side  (mag_side)
    );

    // S14: round, sign, saturate
    logic done_reg;
    rsp_t rsp_reg;

    always_ff @(posedge clk)
    begin
        logic [RT_W:0]           r;
        logic signed [SAT_W-1:0] rp;
        logic signed [SAT_W-1:0] ip;
        logic signed [QM_W:0]    q2;
        r  = {1'b0, mag_root} + (RT_W+1)'(mag_rem > (RT_W+2)'(mag_root));
        rp = $signed(SAT_W'(r));
        ip = mag_side[S2_SIDE-2] ? -rp : rp;
        q2 = $signed(mag_side[QM_W:0]);
        if (mag_side[S2_SIDE-1])
        begin
            rsp_reg.q_in_plane     <= '0;
            rsp_reg.q_out_of_plane <= '0;
            rsp_reg.zero_position  <= 1'b1;
        end
        else
        begin
            rsp_reg.q_in_plane     <= sat_out(ip);
            rsp_reg.q_out_of_plane <= sat_out(SAT_W'(q2));
            rsp_reg.zero_position  <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start && !busy;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= len_vld;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= div_vld;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            done_reg    <= mag_vld;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("response missing after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("response without request");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.zero_position |-> rsp.q_in_plane == '0 && rsp.q_out_of_plane == '0)
        else $error("zero-length position with nonzero output");

endmodule

// ----- dv/pixel_to_momentum_transfer_unit_test.sv -----
// Self-checking testbench for pixel_to_momentum_transfer_unit: random and directed
// pixel positions against a fixed-point predictor, under several register settings.
// Depends on p2q_pkg and the unit's RTL.

module pixel_to_momentum_transfer_unit_test;
    import p2q_pkg::*;

    localparam int LATENCY = 120;
    localparam int LIMIT   = 400000;

    class q_scoreboard;
        logic [CFG_W-1:0]  rows[3];
        logic [CFG_W-1:0]  offs;
        logic [WAVE_W-1:0] wave;
        rsp_t              pending[$];
        int                mismatches;

        function new();
            rows[0] = CFG_W'(1) << FRAC_BITS;
            rows[1] = CFG_W'(1) << (FRAC_BITS + COEF_W);
            rows[2] = CFG_W'(1) << (FRAC_BITS + 2 * COEF_W);
            offs = '0;
            wave = WAVE_W'(1) << FRAC_BITS;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ROW0:   rows[0] = data;
                CFG_ROW1:   rows[1] = data;
                CFG_ROW2:   rows[2] = data;
                CFG_OFFSET: offs = data;
                CFG_WAVE:   wave = data[WAVE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint signed coef_at(logic [CFG_W-1:0] r, int i);
            logic signed [COEF_W-1:0] t;
            t = r[i*COEF_W +: COEF_W];
            return longint'(t);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function longint unsigned abs_of(longint signed v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function logic [OUT_W-1:0] clamp(longint signed v);
            longint signed hi, lo;
            hi = (longint'(1) << (OUT_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[OUT_W-1:0];
        endfunction

        function void note_request(req_t r);
            longint signed   pv[3], p[3], q[3];
            longint unsigned mg[3];
            bit              ng[3];
            longint unsigned m, s, len, dm, am, vm, rs, rr;
            longint signed   d, a, mj, vv, ip;
            rsp_t            e;
            pv[0] = longint'(r.pos_x);
            pv[1] = longint'(r.pos_y);
            pv[2] = longint'(r.pos_z);
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                ng[i] = pv[i] < 0;
                mg[i] = abs_of(pv[i]);
                if (mg[i] > m) m = mg[i];
            end
            e = '0;
            if (m == 0)
            begin
                e.zero_position = 1'b1;
                pending.push_back(e);
                return;
            end
            while (m < (64'd1 << 30))
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++) mg[i] <<= 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                s += mg[i] * mg[i];
                p[i] = ng[i] ? -longint'(mg[i]) : longint'(mg[i]);
            end
            len = int_sqrt(s);
            for (int j = 0; j < 3; j++)
            begin
                d = 0;
                for (int i = 0; i < 3; i++) d += coef_at(rows[j], i) * p[i];
                dm = abs_of(d);
                am = (dm * 512 + len) / (2 * len);
                a = d < 0 ? -longint'(am) : longint'(am);
                mj = a - coef_at(offs, j) * 256;
                vv = mj * longint'({40'd0, wave});
                vm = (abs_of(vv) + (64'd1 << 23)) >> 24;
                q[j] = vv < 0 ? -longint'(vm) : longint'(vm);
            end
            rs = abs_of(q[0]) * abs_of(q[0]) + abs_of(q[1]) * abs_of(q[1]);
            rr = int_sqrt(rs);
            if (rs - rr * rr > rr) rr++;
            ip = q[0] < 0 ? -longint'(rr) : longint'(rr);
            e.q_in_plane = clamp(ip);
            e.q_out_of_plane = clamp(q[2]);
            pending.push_back(e);
        endfunction

        function bit check_response(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
                return 0;
            end
            e = pending.pop_front();
            if (e.q_in_plane !== got.q_in_plane || e.q_out_of_plane !== got.q_out_of_plane
                || e.zero_position !== got.zero_position)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp ip=%0d oop=%0d z=%b got ip=%0d oop=%0d z=%b",
                             e.q_in_plane, e.q_out_of_plane, e.zero_position,
                             got.q_in_plane, got.q_out_of_plane, got.zero_position);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    q_scoreboard sb;
    int          cycles;
    int          idle_pct;

    pixel_to_momentum_transfer_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) void'(sb.check_response(rsp));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("pixel_to_momentum_transfer_unit_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge with start still high
    task automatic send_request(req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        req = r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    // called at a falling edge
    task automatic drain();
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] v;
        int                 w;
        v = COORD_W'($urandom);
        w = $urandom_range(COORD_W - 1, 0);
        if ($urandom_range(3) != 0)
            v = COORD_W'($signed(v << (COORD_W - 1 - w)) >>> (COORD_W - 1 - w));
        return v;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.pos_x = rand_coord();
        r.pos_y = rand_coord();
        r.pos_z = $urandom_range(15) == 0 ? '0 : rand_coord();
        if ($urandom_range(63) == 0) r = '0;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pack3(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                               logic [COEF_W-1:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg();
        logic [CFG_W-1:0] v;
        v = CFG_W'({$urandom, $urandom});
        return v;
    endfunction

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) send_request(rand_req());
    endtask

    task automatic directed_items();
        localparam logic signed [COORD_W-1:0] PMAX = {1'b0, {(COORD_W-1){1'b1}}};
        localparam logic signed [COORD_W-1:0] PMIN = {1'b1, {(COORD_W-1){1'b0}}};
        req_t r;
        r = '0;
        send_request(r);
        r = '{PMAX, PMAX, PMAX};
        send_request(r);
        r = '{PMIN, PMIN, PMIN};
        send_request(r);
        r = '{PMIN, PMAX, '0};
        send_request(r);
        r = '{24'sd1, '0, '0};
        send_request(r);
        r = '{-24'sd1, '0, '0};
        send_request(r);
        r = '{'0, 24'sd1, '0};
        send_request(r);
        r = '{'0, '0, -24'sd1};
        send_request(r);
        r = '{24'sd3, -24'sd4, 24'sd12};
        send_request(r);
        r = '{PMAX, 24'sd1, -24'sd1};
        send_request(r);
        r = '{-24'sd1, PMIN, 24'sd1};
        send_request(r);
        r = '{24'sd1, 24'sd1, 24'sd1};
        send_request(r);
        r = '{-24'sd1, -24'sd1, -24'sd1};
        send_request(r);
    endtask

    task automatic load_all(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1, logic [CFG_W-1:0] r2,
                            logic [CFG_W-1:0] off, logic [CFG_W-1:0] wv);
        write_reg(CFG_ROW0, r0);
        write_reg(CFG_ROW1, r1);
        write_reg(CFG_ROW2, r2);
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_WAVE, wv);
    endtask

    initial
    begin
        logic [COEF_W-1:0] cmax, cmin, cneg1, cone;
        sb = new();
        cycles = 0;
        idle_pct = 19;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROW0;
        cfg_data = '0;
        cmax = {1'b0, {(COEF_W-1){1'b1}}};
        cmin = {1'b1, {(COEF_W-1){1'b0}}};
        cneg1 = '1;
        cone = COEF_W'(1) << FRAC_BITS;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_items();
        random_items(150);
        drain();

        load_all(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
        // unknown indexes must leave the registers alone
        write_reg(CFG_IDX_W'(int'(CFG_WAVE) + 1), rand_cfg());
        write_reg('1, rand_cfg());
        random_items(150);
        drain();

        idle_pct = 55;
        load_all(pack3(cmax, cmax, cmax), pack3(cmin, cmin, cmin), pack3(cmax, cmin, cmax),
                 pack3(cmin, cmax, cmin), '1);
        directed_items();
        random_items(120);
        drain();

        load_all(pack3(cneg1, '0, '0), pack3('0, cone, '0), pack3('0, '0, cone), '0,
                 CFG_W'(1));
        random_items(60);
        drain();

        idle_pct = 0;
        load_all(pack3(cmin, '0, cmax), pack3(cone, cneg1, cmin), pack3('0, '0, '0),
                 pack3(cmax, cmax, cmax), '0);
        directed_items();
        random_items(100);
        drain();

        load_all(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(),
                 CFG_W'($urandom_range(1 << 20, 0)));
        random_items(300);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("pixel_to_momentum_transfer_unit_test OK");
        else
            $display("pixel_to_momentum_transfer_unit_test NOT OK");
        $finish;
    end

endmodule
